### sv/assert_macros.svh
// Assertion macros used by the sweep-and-prune top level.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/sppf_pkg.sv
// Package for the sweep-and-prune pair finder: defaults, codes, states, cell controls.
// No dependencies.
package sppf_pkg;

	localparam int MaxBoxesDef  = 1024;
	localparam int CoordWidthDef = 16;
	localparam int IdW          = 10;
	localparam int InLeftW      = 16;
	localparam int InWidthW     = 8;

	// Request opcodes.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REFRESH,
		ST_SEARCH
	} state_t;

	// Commands broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;        // insert the new box into the sorted row
		logic refresh;    // copy the sorted row into both sweep views
		logic adv_outer;  // move the outer view by one and rebuild the inner view
		logic adv_inner;  // move the inner view by one
	} cell_ctl_t;

endpackage

### sv/sppf_if.sv
// Request and result channel interfaces of the sweep-and-prune pair finder.
// Depends on sppf_pkg.
interface sppf_req_if
	import sppf_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                opcode;
	logic                start_new;
	logic [IdW-1:0]      box_id;
	logic [InLeftW-1:0]  left_x;
	logic [InWidthW-1:0] width;

	modport source(output valid, opcode, start_new, box_id, left_x, width, input ready);
	modport sink(input valid, opcode, start_new, box_id, left_x, width, output ready);
endinterface

interface sppf_rsp_if
	import sppf_pkg::*;
();
	logic           valid;
	logic           ready;
	logic [IdW-1:0] first_id;
	logic [IdW-1:0] second_id;
	logic           pair_valid;
	logic           done_res;
	logic           boxes_dropped;

	modport source(output valid, first_id, second_id, pair_valid, done_res, boxes_dropped,
		input ready);
	modport sink(input valid, first_id, second_id, pair_valid, done_res, boxes_dropped,
		output ready);
endinterface

### sv/sweep_prune_pair_finder.sv
// Top level of the one-axis sweep-and-prune pair finder.
// Depends on sppf_pkg, sppf_if, sppf_cell and assert_macros.svh.
//
// Requests arrive on req. A load request (OP_LOAD) stores one box; start_new
// empties the store first. A fetch request (OP_FETCH) is answered by exactly one
// result on rsp: the next candidate pair of the sweep, or done when none remains.
// A load produces no result. It inserts the box into the sorted chain of cells
// and then holds req in the refresh state to copy the chain into the sweep views.
// A fetch is accepted and then holds req in the search state, in which the outer
// view skips each box with no further partner, until the result register is
// written. The result shows on rsp the cycle after that write.
// Loads beyond MAX_BOXES are dropped and raise the sticky boxes_dropped flag,
// which start_new clears. After reset the store is empty, so a fetch answers done.
// When the receiver stalls rsp, the result waits in the output register. New
// requests are still taken; a fetch search holds before writing its result until
// the register is free, and req.ready stays low meanwhile.
// The state lives in a row of MAX_BOXES identical cells, each holding one sorted
// slot and one slot of the outer and inner views; the views shift one cell a step.
`include "assert_macros.svh"

module sweep_prune_pair_finder
	import sppf_pkg::*;
#(
	parameter int MAX_BOXES   = MaxBoxesDef,
	parameter int COORD_WIDTH = CoordWidthDef
) (
	input logic      clk,
	input logic      arst_n,
	sppf_req_if.sink   req,
	sppf_rsp_if.source rsp
);

	localparam int N     = MAX_BOXES;
	localparam int CW    = COORD_WIDTH;
	localparam int CNT_W = $clog2(N + 1);
	localparam int BW    = 2 * CW + 1 + IdW;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] outer_q, outer_d;
	logic [CNT_W-1:0] inner_q, inner_d;
	logic             ovf_q, ovf_d;
	logic [CNT_W-1:0] eff_count;
	cell_ctl_t        ctl;

	logic             acc;
	logic             is_load;
	logic             can_emit;
	logic             emit, emit_pair;
	logic             at_end, has_pair;

	logic             rsp_valid_q;
	logic [IdW-1:0]   first_q, second_q;
	logic             pair_q, done_q, drop_q;

	logic [CW-1:0]    new_left;
	logic [CW:0]      new_right;
	logic [BW-1:0]    new_box;

	logic [BW-1:0]    st [N];
	logic [BW-1:0]    ov [N];
	logic [BW-1:0]    iv [N];
	logic             gt [N];

	assign req.ready = (state_q == ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign is_load   = acc && (req.opcode == OP_LOAD);

	// Only the low COORD_WIDTH bits of left_x are meaningful.
	generate
		if (CW <= InLeftW) begin : g_left_cut
			assign new_left = req.left_x[CW-1:0];
		end else begin : g_left_ext
			assign new_left = {{(CW - InLeftW){1'b0}}, req.left_x};
		end
	endgenerate
	assign new_right = {1'b0, new_left} + (CW + 1)'(req.width);
	assign new_box   = {req.box_id, new_right, new_left};

	assign eff_count = req.start_new ? '0 : count_q;

	// Search decisions look only at the heads of the two views.
	assign at_end   = ({1'b0, outer_q} + (CNT_W + 1)'(1)) >= {1'b0, count_q};
	assign has_pair = (inner_q < count_q) && ({1'b0, iv[0][CW-1:0]} <= ov[0][2*CW:CW]);
	assign can_emit = !rsp_valid_q || rsp.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					state_d = (req.opcode == OP_FETCH) ? ST_SEARCH : ST_REFRESH;
				end
			end
			ST_REFRESH: state_d = ST_IDLE;
			ST_SEARCH: begin
				if (can_emit && (at_end || has_pair)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl       = '0;
		emit      = 1'b0;
		emit_pair = 1'b0;
		count_d   = count_q;
		outer_d   = outer_q;
		inner_d   = inner_q;
		ovf_d     = ovf_q;
		unique case (state_q)
			ST_IDLE: begin
				if (is_load) begin
					outer_d = '0;
					inner_d = CNT_W'(1);
					ovf_d   = req.start_new ? 1'b0 : ovf_q;
					if (eff_count >= CNT_W'(N)) begin
						ovf_d = 1'b1;
					end else begin
						ctl.ins = 1'b1;
						count_d = eff_count + CNT_W'(1);
					end
				end
			end
			ST_REFRESH: ctl.refresh = 1'b1;
			ST_SEARCH: begin
				if (at_end) begin
					emit = can_emit;
				end else if (has_pair) begin
					if (can_emit) begin
						emit          = 1'b1;
						emit_pair     = 1'b1;
						ctl.adv_inner = 1'b1;
						inner_d       = inner_q + CNT_W'(1);
					end
				end else begin
					ctl.adv_outer = 1'b1;
					outer_d       = outer_q + CNT_W'(1);
					inner_d       = outer_q + CNT_W'(2);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			outer_q     <= '0;
			inner_q     <= CNT_W'(1);
			ovf_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			outer_q <= outer_d;
			inner_q <= inner_d;
			ovf_q   <= ovf_d;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			first_q  <= emit_pair ? ov[0][BW-1 -: IdW] : '0;
			second_q <= emit_pair ? iv[0][BW-1 -: IdW] : '0;
			pair_q   <= emit_pair;
			done_q   <= !emit_pair;
			drop_q   <= ovf_q;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.first_id      = first_q;
	assign rsp.second_id     = second_q;
	assign rsp.pair_valid    = pair_q;
	assign rsp.done_res      = done_q;
	assign rsp.boxes_dropped = drop_q;

	// The chain: each cell talks to its left neighbor for insertion and to its
	// right neighbors for the sweep views. Ends are tied off with zeros.
	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_cell
			logic          gp;
			logic [BW-1:0] sp, sn, on, on2, inx;
			if (k == 0) begin : g_first
				assign gp = 1'b0;
				assign sp = '0;
			end else begin : g_mid
				assign gp = gt[k-1];
				assign sp = st[k-1];
			end
			if (k + 1 < N) begin : g_nx
				assign sn  = st[k+1];
				assign on  = ov[k+1];
				assign inx = iv[k+1];
			end else begin : g_nx_end
				assign sn  = '0;
				assign on  = '0;
				assign inx = '0;
			end
			if (k + 2 < N) begin : g_nx2
				assign on2 = ov[k+2];
			end else begin : g_nx2_end
				assign on2 = '0;
			end
			sppf_cell #(
				.K(k), .N(N), .CW(CW), .CNT_W(CNT_W), .BW(BW)
			) u_cell (
				.clk(clk), .ctl(ctl), .eff_count(eff_count),
				.new_box(new_box), .gt_prev(gp), .gt(gt[k]),
				.st_prev(sp), .st_next(sn), .ov_next(on), .ov_next2(on2), .iv_next(inx),
				.st(st[k]), .ov(ov[k]), .iv(iv[k])
			);
		end
	endgenerate

	`ASSERT_SAME(a_pair_xor_done, rsp_valid_q, !(pair_q && done_q), "pair and done both set")
	`ASSERT_SAME(a_count_bound, 1'b1, count_q <= CNT_W'(N), "box count above capacity")
	`ASSERT_NEXT(a_load_refresh, is_load, state_q == ST_REFRESH, "load not followed by refresh")
	`ASSERT_SAME(a_inner_after_outer, state_q == ST_SEARCH, inner_q > outer_q,
		"inner index not past outer index")

endmodule

### sv/sppf_cell.sv
// One cell of the pair finder chain: a sorted-row slot plus outer and inner sweep views.
// Depends on sppf_pkg.
module sppf_cell
	import sppf_pkg::*;
#(
	parameter int K     = 0,
	parameter int N     = MaxBoxesDef,
	parameter int CW    = CoordWidthDef,
	parameter int CNT_W = $clog2(N + 1),
	parameter int BW    = 2 * CW + 1 + IdW
) (
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [CNT_W-1:0] eff_count,
	input  logic [BW-1:0]    new_box,
	input  logic             gt_prev,
	output logic             gt,
	input  logic [BW-1:0]    st_prev,
	input  logic [BW-1:0]    st_next,
	input  logic [BW-1:0]    ov_next,
	input  logic [BW-1:0]    ov_next2,
	input  logic [BW-1:0]    iv_next,
	output logic [BW-1:0]    st,
	output logic [BW-1:0]    ov,
	output logic [BW-1:0]    iv
);

	logic [BW-1:0] st_q, ov_q, iv_q;
	logic          occ;

	// A slot is greater than the new box when it is empty or its left is larger.
	assign occ = CNT_W'(K) < eff_count;
	assign gt  = !occ || (st_q[CW-1:0] > new_box[CW-1:0]);

	// Payload only; occupancy comes from the box count, so no reset is needed.
	always_ff @(posedge clk) begin
		if (ctl.ins && gt) begin
			st_q <= gt_prev ? st_prev : new_box;
		end
		if (ctl.refresh) begin
			ov_q <= st_q;
			iv_q <= st_next;
		end else if (ctl.adv_outer) begin
			ov_q <= ov_next;
			iv_q <= ov_next2;
		end else if (ctl.adv_inner) begin
			iv_q <= iv_next;
		end
	end

	assign st = st_q;
	assign ov = ov_q;
	assign iv = iv_q;

endmodule

### dv/sppf_tb_if.sv
`timescale 1ns / 1ps
// Testbench request and result item types of the sweep-and-prune pair finder.
// Depends on sppf_pkg.
package sppf_tb_types;
	import sppf_pkg::*;

	typedef struct {
		logic            opcode;
		logic            start_new;
		logic [IdW-1:0]  box_id;
		logic [InLeftW-1:0] left_x;
		logic [InWidthW-1:0] width;
	} box_req_t;

	typedef struct {
		logic [IdW-1:0] first_id;
		logic [IdW-1:0] second_id;
		logic           pair_valid;
		logic           done_res;
		logic           boxes_dropped;
	} pair_rsp_t;
endpackage

### dv/testbench.sv
`timescale 1ns / 1ps
// Testbench of the sweep-and-prune pair finder: directed and random requests.
// Depends on sppf_pkg, the sppf_req_if/sppf_rsp_if interfaces, sppf_tb_types and sweep_prune_pair_finder.
module testbench;
	import sppf_pkg::*;
	import sppf_tb_types::*;

	localparam int NBOX = MaxBoxesDef;
	localparam int LIMIT = 1500000;

	logic clk;
	logic arst_n;

	sppf_req_if req ();
	sppf_rsp_if rsp ();

	sweep_prune_pair_finder dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	// Shadow of the sorted box store, kept in load-tie order like the block.
	logic [15:0] shadow_left [NBOX];
	logic [16:0] shadow_right [NBOX];
	logic [9:0]  shadow_id [NBOX];
	int unsigned stored_boxes = 0;
	int unsigned sweep_outer = 0;
	int unsigned sweep_inner = 1;
	logic        store_overflowed = 1'b0;

	box_req_t  pending_reqs [$];
	pair_rsp_t expected_pairs [$];

	int  fail_count = 0;
	longint cycle_count;
	bit  stimulus_done;
	bit  rsp_hold_off;
	bit  no_idle;
	bit  req_taken;

	// Applies one accepted request to the shadow store and, for a fetch,
	// appends the expected result.
	task automatic predict_request(input box_req_t r);
		pair_rsp_t res;
		int unsigned pos;
		if (r.opcode == OP_LOAD) begin
			if (r.start_new) begin
				stored_boxes = 0;
				store_overflowed = 1'b0;
			end
			sweep_outer = 0;
			sweep_inner = 1;
			if (stored_boxes >= NBOX) begin
				store_overflowed = 1'b1;
			end else begin
				pos = stored_boxes;
				while (pos > 0 && shadow_left[pos-1] > r.left_x) begin
					shadow_left[pos] = shadow_left[pos-1];
					shadow_right[pos] = shadow_right[pos-1];
					shadow_id[pos] = shadow_id[pos-1];
					pos--;
				end
				shadow_left[pos] = r.left_x;
				shadow_right[pos] = {1'b0, r.left_x} + 17'(r.width);
				shadow_id[pos] = r.box_id;
				stored_boxes++;
			end
			return;
		end
		res = '{first_id: '0, second_id: '0, pair_valid: 1'b0, done_res: 1'b0,
			boxes_dropped: store_overflowed};
		// Skip outer boxes until a partner is found or the sweep is exhausted.
		while (sweep_outer + 1 < stored_boxes) begin
			if (sweep_inner < stored_boxes &&
					{1'b0, shadow_left[sweep_inner]} <= shadow_right[sweep_outer]) begin
				res.first_id = shadow_id[sweep_outer];
				res.second_id = shadow_id[sweep_inner];
				res.pair_valid = 1'b1;
				sweep_inner++;
				expected_pairs.insert(expected_pairs.size(), res);
				return;
			end
			sweep_outer++;
			sweep_inner = sweep_outer + 1;
		end
		res.done_res = 1'b1;
		expected_pairs.insert(expected_pairs.size(), res);
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
		fail_count++;
	endtask

	// Appends one request to the tail of the pending queue.
	task automatic queue_req(input box_req_t r);
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	function automatic box_req_t make_load(input bit fresh, input int left, input int wid);
		box_req_t r;
		r.opcode = OP_LOAD;
		r.start_new = fresh;
		r.box_id = 10'($urandom);
		r.left_x = 16'(left);
		r.width = 8'(wid);
		return r;
	endfunction

	function automatic box_req_t make_fetch();
		box_req_t r;
		// Fields other than the opcode are don't-care on a fetch, so randomize them.
		r.opcode = OP_FETCH;
		r.start_new = 1'($urandom);
		r.box_id = 10'($urandom);
		r.left_x = 16'($urandom);
		r.width = 8'($urandom);
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Reset is asserted at time zero and released on a falling edge.
	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Stimulus: directed corners, a full-store overflow set, then random sets.
	initial begin
		int nsets, nb, base, spread;
		box_req_t r;
		stimulus_done = 1'b0;

		// Fetches on an empty store, then a single box: both answer done.
		queue_req(make_fetch());
		queue_req(make_fetch());
		queue_req(make_load(1, 16'hFFFF, 8'hFF));
		queue_req(make_fetch());
		// Extremes: right edge past the coordinate range, zero widths, ties.
		queue_req(make_load(0, 16'hFF00, 0));
		queue_req(make_load(0, 0, 0));
		queue_req(make_load(0, 0, 8'hFF));
		queue_req(make_load(0, 16'hFFFF, 0));
		queue_req(make_load(0, 8'hFF, 1));
		r = make_load(0, 16'h8000, 8'h80);
		r.box_id = 10'h3FF;
		queue_req(r);
		r = make_load(0, 16'h7FFF, 8'h7F);
		r.box_id = 10'h000;
		queue_req(r);
		repeat (6) queue_req(make_fetch());
		// Load in the middle of a sweep restarts it.
		queue_req(make_load(0, 16'h7FFF, 1));
		repeat (8) queue_req(make_fetch());

		// Fill the store to capacity, then overflow it; rare but must be seen once.
		queue_req(make_load(1, $urandom_range(0, 3000), $urandom));
		for (int i = 1; i < NBOX + 2; i++)
			queue_req(make_load(0, $urandom_range(0, 3000), $urandom_range(0, 3)));
		repeat (4) queue_req(make_fetch());
		// A fresh set clears the overflow flag.
		queue_req(make_load(1, 100, 5));
		queue_req(make_load(0, 103, 5));
		repeat (3) queue_req(make_fetch());

		// Random sets: small dense or sparse sets with fetches run past done.
		nsets = 0;
		while (nsets < 28) begin
			nb = $urandom_range(0, 9);
			base = $urandom_range(0, 65535);
			spread = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(1, 600);
			for (int i = 0; i < nb; i++) begin
				r = make_load(i == 0 || $urandom_range(0, 20) == 0,
					($urandom_range(0, 4) == 0) ? base : (base + $urandom_range(0, spread)) & 16'hFFFF,
					$urandom);
				queue_req(r);
				if ($urandom_range(0, 9) == 0) queue_req(make_fetch());
			end
			repeat ($urandom_range(1, 14)) queue_req(make_fetch());
			nsets++;
		end

		wait (pending_reqs.size() == 0 && arst_n);
		stimulus_done = 1'b1;
	end

	// Long stretch with no idling, and one long receiver hold-off while the
	// random sets, which are rich in fetches, are being sent.
	initial begin
		no_idle = 1'b0;
		rsp_hold_off = 1'b0;
		wait (arst_n);
		repeat (400) @(posedge clk);
		no_idle = 1'b1;
		repeat (1500) @(posedge clk);
		no_idle = 1'b0;
		wait (pending_reqs.size() < 250);
		rsp_hold_off = 1'b1;
		repeat (300) @(posedge clk);
		rsp_hold_off = 1'b0;
	end

	// Records whether the request on the bus was taken at this rising edge.
	always @(posedge clk) begin
		req_taken <= req.valid && req.ready;
	end

	// Request driver: changes on the falling edge, fed from pending_reqs.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.opcode <= OP_LOAD;
			req.start_new <= 1'b0;
			req.box_id <= '0;
			req.left_x <= '0;
			req.width <= '0;
		end else if (!req.valid || req_taken) begin
			// The previous request, if any, was taken at the last rising edge.
			if (pending_reqs.size() > 0 && (no_idle || $urandom_range(0, 99) >= 38)) begin
				req.valid <= 1'b1;
				req.opcode <= pending_reqs[0].opcode;
				req.start_new <= pending_reqs[0].start_new;
				req.box_id <= pending_reqs[0].box_id;
				req.left_x <= pending_reqs[0].left_x;
				req.width <= pending_reqs[0].width;
				pending_reqs.pop_front();
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= !rsp_hold_off && (no_idle || $urandom_range(0, 99) >= 38);
	end

	// Monitor: samples both channels at the rising edge.
	always @(posedge clk) begin
		box_req_t r;
		pair_rsp_t want;
		if (!arst_n) begin
			cycle_count <= 0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (req.valid && req.ready) begin
				r.opcode = req.opcode;
				r.start_new = req.start_new;
				r.box_id = req.box_id;
				r.left_x = req.left_x;
				r.width = req.width;
				predict_request(r);
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_pairs.size() == 0) begin
					report_mismatch("unexpected result, pair_valid", rsp.pair_valid, 0);
				end else begin
					want = expected_pairs.pop_front();
					if (rsp.first_id !== want.first_id)
						report_mismatch("first_id", rsp.first_id, want.first_id);
					if (rsp.second_id !== want.second_id)
						report_mismatch("second_id", rsp.second_id, want.second_id);
					if (rsp.pair_valid !== want.pair_valid)
						report_mismatch("pair_valid", rsp.pair_valid, want.pair_valid);
					if (rsp.done_res !== want.done_res)
						report_mismatch("done_res", rsp.done_res, want.done_res);
					if (rsp.boxes_dropped !== want.boxes_dropped)
						report_mismatch("boxes_dropped", rsp.boxes_dropped, want.boxes_dropped);
				end
			end
		end
	end

	// End of run: drain, settle, then report; a timeout fails the run.
	initial begin
		fork
			begin
				wait (stimulus_done);
				@(negedge clk);
				wait (!req.valid && expected_pairs.size() == 0);
				repeat (NBOX + 20) @(posedge clk);
				if (fail_count == 0 && expected_pairs.size() == 0)
					$display("Test completed successfully");
				else
					$display("Test completed with failures");
			end
			begin
				wait (cycle_count >= LIMIT);
				$display("TIMEOUT after %0d cycles", cycle_count);
				$display("Test completed with failures");
			end
		join_any
		$finish;
	end
endmodule

### sweep_prune_pair_finder.f
+incdir+sv
sv/sppf_pkg.sv
sv/sppf_if.sv
sv/sppf_cell.sv
sv/sweep_prune_pair_finder.sv
dv/sppf_tb_if.sv
dv/testbench.sv
